@@ design/lbm_d3q19_macro_moments_core_assert.svh @@
// Assertion macros used by the port-level checker of the moments core.
`ifndef LBM_D3Q19_MACRO_MOMENTS_CORE_ASSERT_SVH
`define LBM_D3Q19_MACRO_MOMENTS_CORE_ASSERT_SVH

// Checked at every rising edge of clk while rst is low.
`define LBM_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define LBM_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/lbm_pkg.sv @@
// Shared types and constants of the lattice-Boltzmann moments core.
package lbm_pkg;

   localparam int ACC_W       = 40;
   localparam int VAL_W       = 32;
   localparam int DIR_W       = 5;
   localparam int TAU_W       = 32;
   localparam int NUM_AXES    = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 128;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 136;
   localparam int RSP_TUSER_W = 1;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIR_X = 2'd0,
      CSR_DIR_Y = 2'd1,
      CSR_DIR_Z = 2'd2,
      CSR_RELAX = 2'd3
   } csr_idx_type;

   localparam logic [1:0] COMP_ZERO = 2'b00;
   localparam logic [1:0] COMP_POS1 = 2'b01;
   localparam logic [1:0] COMP_NEG2 = 2'b10;
   localparam logic [1:0] COMP_NEG1 = 2'b11;

   typedef struct packed {
      logic [ACC_W-1:0]                density;
      logic [NUM_AXES-1:0][ACC_W-1:0]  mom;
      logic [NUM_AXES-1:0][VAL_W-1:0]  frc;
   } job_type;

   typedef struct packed {
      logic load;
      logic add;
      logic absv;
      logic init;
      logic step;
   } lane_ctrl_type;

endpackage

@@ design/lbm_front.sv @@
// Front end: accepts distribution words and accumulates density and momentum per node.
module lbm_front #(
   parameter int NUM_DIRECTIONS = 19
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lbm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [lbm_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  logic                             req_tlast,
   input  logic [2*NUM_DIRECTIONS-1:0]      dir_x_tbl,
   input  logic [2*NUM_DIRECTIONS-1:0]      dir_y_tbl,
   input  logic [2*NUM_DIRECTIONS-1:0]      dir_z_tbl,
   input  logic                             q_full,
   output logic                             push,
   output lbm_pkg::job_type                 push_job
);
   import lbm_pkg::*;

   logic [ACC_W-1:0]                dens_ff, dens_in, dens_sum;
   logic [NUM_AXES-1:0][ACC_W-1:0]  mom_ff, mom_in, mom_sum, contrib;
   logic [NUM_AXES-1:0][1:0]        comp;
   logic [VAL_W-1:0]                dist_val;
   logic [ACC_W-1:0]                dist_ext, dist_neg, dist_neg2;
   logic                            accept, dir_ok;

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & req_tready;
   assign dist_val   = req_tdata[VAL_W-1:0];
   assign dist_ext   = {{(ACC_W-VAL_W){dist_val[VAL_W-1]}}, dist_val};
   assign dist_neg   = ACC_W'(0) - dist_ext;
   assign dist_neg2  = {dist_neg[ACC_W-2:0], 1'b0};
   assign dir_ok     = req_tuser < DIR_W'(NUM_DIRECTIONS);

   always_comb begin
      comp[0] = dir_ok ? 2'(dir_x_tbl >> {req_tuser, 1'b0}) : COMP_ZERO;
      comp[1] = dir_ok ? 2'(dir_y_tbl >> {req_tuser, 1'b0}) : COMP_ZERO;
      comp[2] = dir_ok ? 2'(dir_z_tbl >> {req_tuser, 1'b0}) : COMP_ZERO;
      for (int a = 0; a < NUM_AXES; a++) begin
         case (comp[a])
            COMP_POS1: contrib[a] = dist_ext;
            COMP_NEG1: contrib[a] = dist_neg;
            COMP_NEG2: contrib[a] = dist_neg2;
            default:   contrib[a] = '0;
         endcase
         mom_sum[a] = mom_ff[a] + contrib[a];
      end
      dens_sum = dens_ff + dist_ext;
   end

   always_comb begin
      dens_in = dens_ff;
      mom_in  = mom_ff;
      if (accept) begin
         if (req_tlast) begin
            dens_in = '0;
            mom_in  = '0;
         end else begin
            dens_in = dens_sum;
            mom_in  = mom_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dens_ff <= '0;
         mom_ff  <= '0;
      end else begin
         dens_ff <= dens_in;
         mom_ff  <= mom_in;
      end
   end

   assign push             = accept & req_tlast;
   assign push_job.density = dens_sum;
   assign push_job.mom     = mom_sum;
   assign push_job.frc[0]  = req_tdata[2*VAL_W-1:VAL_W];
   assign push_job.frc[1]  = req_tdata[3*VAL_W-1:2*VAL_W];
   assign push_job.frc[2]  = req_tdata[4*VAL_W-1:3*VAL_W];

endmodule

@@ design/lbm_queue.sv @@
// Short queue of finished node sums between the front end and the back end.
module lbm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lbm_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output lbm_pkg::job_type pop_job,
   output logic             empty
);
   import lbm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full    = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign pop_job = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ design/lbm_lane.sv @@
// One velocity lane: force term, numerator, and a one-bit-per-cycle divider with saturation.
module lbm_lane #(
   parameter int FRACTION_BITS = 24
) (
   input  logic                         clock,
   input  lbm_pkg::lane_ctrl_type       ctrl,
   input  logic [lbm_pkg::TAU_W-1:0]    tau,
   input  logic [lbm_pkg::ACC_W-1:0]    mom,
   input  logic [lbm_pkg::VAL_W-1:0]    frc,
   input  logic [lbm_pkg::ACC_W-1:0]    dmag,
   input  logic                         rho_neg,
   output logic [lbm_pkg::VAL_W-1:0]    vel
);
   import lbm_pkg::*;

   localparam int PROD_W = TAU_W + 1 + VAL_W;
   localparam int TF_W   = PROD_W - FRACTION_BITS;
   localparam int NUM_W  = ((TF_W > ACC_W) ? TF_W : ACC_W) + 1;
   localparam int QB     = VAL_W - 1;
   localparam int SAT_SH = QB - FRACTION_BITS;
   localparam int CMP_W  = (NUM_W > ACC_W + SAT_SH) ? NUM_W : ACC_W + SAT_SH;
   localparam int NP_W   = NUM_W + FRACTION_BITS;
   localparam int REM_W  = ACC_W + 1;

   logic signed [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]         mom_ff;
   logic signed [NUM_W-1:0]  num_ff, mom_x, tf_x;
   logic [NUM_W-1:0]         mag_ff;
   logic                     neg_ff, sat_ff, ge;
   logic [REM_W-1:0]         rem_ff;
   logic [REM_W:0]           rem2, dext;
   logic [QB-1:0]            low_ff, quo_ff;
   logic [NP_W-1:0]          nprime;
   logic [VAL_W-1:0]         quo_ext;

   assign mom_x  = NUM_W'($signed(mom_ff));
   assign tf_x   = NUM_W'(prod_ff >>> FRACTION_BITS);
   assign nprime = {mag_ff, {FRACTION_BITS{1'b0}}};
   assign rem2   = {rem_ff, low_ff[QB-1]};
   assign dext   = (REM_W + 1)'(dmag);
   assign ge     = rem2 >= dext;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= $signed({1'b0, tau}) * $signed(frc);
         mom_ff  <= mom;
      end
      if (ctrl.add) begin
         num_ff <= mom_x + tf_x;
      end
      if (ctrl.absv) begin
         neg_ff <= num_ff[NUM_W-1] ^ rho_neg;
         mag_ff <= num_ff[NUM_W-1] ? NUM_W'(0) - NUM_W'(num_ff) : NUM_W'(num_ff);
      end
      if (ctrl.init) begin
         sat_ff <= CMP_W'(mag_ff) >= (CMP_W'(dmag) << SAT_SH);
         rem_ff <= REM_W'(nprime >> QB);
         low_ff <= nprime[QB-1:0];
         quo_ff <= '0;
      end
      if (ctrl.step) begin
         rem_ff <= ge ? REM_W'(rem2 - dext) : REM_W'(rem2);
         quo_ff <= {quo_ff[QB-2:0], ge};
         low_ff <= {low_ff[QB-2:0], 1'b0};
      end
   end

   assign quo_ext = {1'b0, quo_ff};

   always_comb begin
      if (sat_ff) begin
         vel = neg_ff ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
      end else begin
         vel = neg_ff ? VAL_W'(0) - quo_ext : quo_ext;
      end
   end

endmodule

@@ design/lbm_back.sv @@
// Back end: takes node sums from the queue, runs three velocity lanes and holds the result word.
module lbm_back #(
   parameter int FRACTION_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   output logic                             q_pop,
   input  lbm_pkg::job_type                 q_job,
   input  logic [lbm_pkg::TAU_W-1:0]        tau,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lbm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [lbm_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import lbm_pkg::*;

   localparam int STEPS = VAL_W - 1;
   localparam int CNT_W = $clog2(STEPS);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_ADD  = 6'b000010,
      ST_ABS  = 6'b000100,
      ST_INIT = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [ACC_W-1:0]                dens_ff, dmag_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]          rsp_data_ff;
   logic [RSP_TUSER_W-1:0]          rsp_user_ff;
   logic                            out_free, out_load, zero;
   lane_ctrl_type                   ctrl;
   logic [NUM_AXES-1:0][VAL_W-1:0]  vel;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign zero     = dens_ff == '0;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctrl      = '0;
      q_pop     = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               ctrl.load = 1'b1;
               state_in  = ST_ADD;
            end
         end
         ST_ADD: begin
            ctrl.add = 1'b1;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            ctrl.absv = 1'b1;
            state_in  = ST_INIT;
         end
         ST_INIT: begin
            ctrl.init = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            ctrl.step = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         dens_ff <= q_job.density;
      end
      if (ctrl.add) begin
         dmag_ff <= dens_ff[ACC_W-1] ? ACC_W'(0) - dens_ff : dens_ff;
      end
      if (out_load) begin
         rsp_data_ff <= zero ? {{(NUM_AXES*VAL_W){1'b0}}, dens_ff}
                             : {vel[2], vel[1], vel[0], dens_ff};
         rsp_user_ff <= RSP_TUSER_W'(zero);
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      lbm_lane #(
         .FRACTION_BITS (FRACTION_BITS)
      ) u_lane (
         .clock   (clock),
         .ctrl    (ctrl),
         .tau     (tau),
         .mom     (q_job.mom[a]),
         .frc     (q_job.frc[a]),
         .dmag    (dmag_ff),
         .rho_neg (dens_ff[ACC_W-1]),
         .vel     (vel[a])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ design/lbm_d3q19_macro_moments_core.sv @@
// Top level of the D3Q19 macroscopic moments core with its configuration registers.
// The last value of a node pushes its sums into a two-entry queue. The back end pops them
// and, in three velocity lanes in parallel, runs the add, absolute-value, init, 31-step
// divide and done states, then registers the result word on rsp_tvalid. The front end
// takes one value per cycle while the queue is not full; the back end, one node at a time.
// Reset clears the sums, the queue, the output valid, the tables, and sets tau to 1.0.
module lbm_d3q19_macro_moments_core #(
   parameter int NUM_DIRECTIONS = 19,
   parameter int FRACTION_BITS  = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: dist_value, force_x, force_y, force_z.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lbm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: direction.
   input  logic [lbm_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: density, vel_x, vel_y, vel_z.
   output logic [lbm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: zero_density.
   output logic [lbm_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [((2*NUM_DIRECTIONS > lbm_pkg::TAU_W) ? 2*NUM_DIRECTIONS
                                                     : lbm_pkg::TAU_W)-1:0] csr_data
);
   import lbm_pkg::*;

   localparam int TBL_W = 2 * NUM_DIRECTIONS;

   logic [TBL_W-1:0]  dir_x_ff, dir_x_in, dir_y_ff, dir_y_in, dir_z_ff, dir_z_in;
   logic [TAU_W-1:0]  tau_ff, tau_in;
   logic              csr_wr, q_full, q_empty, push, pop;
   job_type           push_job, pop_job;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_comb begin
      dir_x_in = dir_x_ff;
      dir_y_in = dir_y_ff;
      dir_z_in = dir_z_ff;
      tau_in   = tau_ff;
      if (csr_wr) begin
         case (csr_idx_type'(csr_index))
            CSR_DIR_X: dir_x_in = TBL_W'(csr_data);
            CSR_DIR_Y: dir_y_in = TBL_W'(csr_data);
            CSR_DIR_Z: dir_z_in = TBL_W'(csr_data);
            CSR_RELAX: tau_in   = TAU_W'(csr_data);
            default:   tau_in   = tau_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_x_ff <= '0;
         dir_y_ff <= '0;
         dir_z_ff <= '0;
         tau_ff   <= TAU_W'(1) << FRACTION_BITS;
      end else begin
         dir_x_ff <= dir_x_in;
         dir_y_ff <= dir_y_in;
         dir_z_ff <= dir_z_in;
         tau_ff   <= tau_in;
      end
   end

   lbm_front #(
      .NUM_DIRECTIONS (NUM_DIRECTIONS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .dir_x_tbl  (dir_x_ff),
      .dir_y_tbl  (dir_y_ff),
      .dir_z_tbl  (dir_z_ff),
      .q_full     (q_full),
      .push       (push),
      .push_job   (push_job)
   );

   lbm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   lbm_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_pop      (pop),
      .q_job      (pop_job),
      .tau        (tau_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ design/lbm_chk.sv @@
// Port-level checker for the moments core, bound to the top level.
`include "lbm_d3q19_macro_moments_core_assert.svh"

module lbm_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lbm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [lbm_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import lbm_pkg::*;

   `LBM_ASSERT(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "result word valid after reset")
   `LBM_ASSERT_RST(a_hold_stalled, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result word changed")
   `LBM_ASSERT_RST(a_zero_flag, clock, reset, rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[ACC_W-1:0] == '0)), "zero density flag disagrees with density")
   `LBM_ASSERT_RST(a_zero_vel, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[RSP_TDATA_W-1:ACC_W] == '0, "velocities not zero at zero density")

endmodule

bind lbm_d3q19_macro_moments_core lbm_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
